@@ src/csvfs_pkg.sv @@
package csvfs_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = $clog2(QDEPTH);

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] SEPARATOR_RESET = 8'd44;
	localparam logic [7:0] QUOTE_CHAR_RESET = 8'd34;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_EOF = 2'd1;
	localparam logic [1:0] KIND_EOR = 2'd2;

	localparam logic CFG_SEPARATOR = 1'b0;
	localparam logic CFG_QUOTE_CHAR = 1'b1;

	typedef enum logic [3:0] {
		MODE_START = 4'b0001,
		MODE_PLAIN = 4'b0010,
		MODE_QUOTED = 4'b0100,
		MODE_QSEEN = 4'b1000
	} mode_t;

	typedef struct packed {
		logic command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [7:0] field_index;
		logic [8:0] field_count;
		logic overflow;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic two;
		out_item_t r0;
		out_item_t r1;
	} entry_t;

endpackage

@@ src/csvfs_front.sv @@
module csvfs_front #(
	parameter int unsigned MAX_FIELDS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [7:0] cfg_data,
	input logic in_valid,
	input csvfs_pkg::in_item_t in_item,
	input logic full,
	output logic push,
	output csvfs_pkg::entry_t push_entry
);

	localparam int unsigned CW = $clog2(MAX_FIELDS);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FIELDS - 1);

	logic [7:0] separator_q;
	logic [7:0] quote_q;
	csvfs_pkg::mode_t mode_q, mode_d;
	logic cr_q, cr_d;
	logic bytes_q, bytes_d;
	logic text_q, text_d;
	logic cut_q, cut_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic ovf_q, ovf_d;

	logic [7:0] b;
	logic accept;
	logic plain;
	logic finish;
	logic clear;
	logic [1:0] n;
	logic [CW+8:0] cnt_wide;
	logic [CW+8:0] cnt_plus;
	logic [7:0] idx;
	logic [8:0] count;
	csvfs_pkg::out_item_t r0, r1;

	assign b = in_item.data_byte;
	assign accept = in_valid && !full;
	assign cnt_wide = (CW+9)'(cnt_q);
	assign cnt_plus = cnt_wide + (CW+9)'(1);
	assign idx = cnt_wide[7:0];
	assign count = cnt_plus[8:0];

	always_comb begin
		mode_d = mode_q;
		cr_d = cr_q;
		bytes_d = bytes_q;
		text_d = text_q;
		cut_d = cut_q;
		cnt_d = cnt_q;
		ovf_d = ovf_q;
		plain = 1'b0;
		finish = 1'b0;
		clear = 1'b0;
		n = 2'd0;
		r0 = '0;
		r1 = '0;
		r0.overflow = ovf_q;
		r1.overflow = ovf_q;
		r0.field_index = idx;
		r1.field_index = idx;
		if (in_item.command) begin
			cr_d = 1'b0;
			if (bytes_q) begin
				finish = 1'b1;
			end else begin
				clear = 1'b1;
			end
		end else if (cr_q && b == csvfs_pkg::CH_LF) begin
			cr_d = 1'b0;
		end else begin
			cr_d = 1'b0;
			if (b == csvfs_pkg::CH_CR || b == csvfs_pkg::CH_LF) begin
				finish = 1'b1;
				cr_d = (b == csvfs_pkg::CH_CR);
			end else begin
				bytes_d = 1'b1;
				if (!cut_q) begin
					if (b == csvfs_pkg::CH_NUL) begin
						cut_d = 1'b1;
					end else begin
						text_d = 1'b1;
						unique case (mode_q)
							csvfs_pkg::MODE_START: begin
								if (b == quote_q) begin
									mode_d = csvfs_pkg::MODE_QUOTED;
								end else begin
									plain = 1'b1;
								end
							end
							csvfs_pkg::MODE_QUOTED: begin
								if (b == quote_q) begin
									mode_d = csvfs_pkg::MODE_QSEEN;
								end else begin
									r0.kind = csvfs_pkg::KIND_BYTE;
									r0.out_byte = b;
									n = 2'd1;
								end
							end
							csvfs_pkg::MODE_QSEEN: begin
								if (b == quote_q) begin
									r0.kind = csvfs_pkg::KIND_BYTE;
									r0.out_byte = quote_q;
									n = 2'd1;
									mode_d = csvfs_pkg::MODE_QUOTED;
								end else begin
									plain = 1'b1;
								end
							end
							default: begin
								plain = 1'b1;
							end
						endcase
						if (plain) begin
							if (b == separator_q) begin
								r0.kind = csvfs_pkg::KIND_EOF;
								n = 2'd1;
								if (cnt_q != CNT_MAX) begin
									cnt_d = cnt_q + CW'(1);
								end else begin
									ovf_d = 1'b1;
								end
								mode_d = csvfs_pkg::MODE_START;
							end else begin
								r0.kind = csvfs_pkg::KIND_BYTE;
								r0.out_byte = b;
								n = 2'd1;
								mode_d = csvfs_pkg::MODE_PLAIN;
							end
						end
					end
				end
			end
		end
		if (finish) begin
			clear = 1'b1;
			if (text_q) begin
				r0.kind = csvfs_pkg::KIND_EOF;
				r1.kind = csvfs_pkg::KIND_EOR;
				r1.field_count = count;
				n = 2'd2;
			end else begin
				r0.kind = csvfs_pkg::KIND_EOR;
				r0.field_index = '0;
				n = 2'd1;
			end
		end
		if (clear) begin
			mode_d = csvfs_pkg::MODE_START;
			bytes_d = 1'b0;
			text_d = 1'b0;
			cut_d = 1'b0;
			cnt_d = '0;
			ovf_d = 1'b0;
		end
		r0.last = (n == 2'd1);
		r1.last = 1'b1;
	end

	assign push = accept && (n != 2'd0);
	assign push_entry = '{two: (n == 2'd2), r0: r0, r1: r1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= csvfs_pkg::SEPARATOR_RESET;
			quote_q <= csvfs_pkg::QUOTE_CHAR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csvfs_pkg::CFG_SEPARATOR: separator_q <= cfg_data;
				csvfs_pkg::CFG_QUOTE_CHAR: quote_q <= cfg_data;
				default: separator_q <= separator_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csvfs_pkg::MODE_START;
			cr_q <= 1'b0;
			bytes_q <= 1'b0;
			text_q <= 1'b0;
			cut_q <= 1'b0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			cr_q <= cr_d;
			bytes_q <= bytes_d;
			text_q <= text_d;
			cut_q <= cut_d;
			cnt_q <= cnt_d;
			ovf_q <= ovf_d;
		end
	end

endmodule

@@ src/csvfs_fifo.sv @@
module csvfs_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input csvfs_pkg::entry_t push_entry,
	input logic pop,
	output logic full,
	output logic not_empty,
	output csvfs_pkg::entry_t head
);

	localparam int unsigned AW = csvfs_pkg::QAW;

	csvfs_pkg::entry_t mem_q [csvfs_pkg::QDEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == (AW+1)'(csvfs_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

@@ src/csvfs_back.sv @@
module csvfs_back (
	input logic clk,
	input logic arst_n,
	input logic not_empty,
	input csvfs_pkg::entry_t head,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output csvfs_pkg::out_item_t out_item
);

	logic out_valid_q;
	csvfs_pkg::out_item_t out_q;
	logic half_q;
	logic load;

	assign load = !out_valid_q || !out_stall;
	assign pop = load && not_empty && (half_q || !head.two);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk) begin
		if (load && not_empty) begin
			out_q <= half_q ? head.r1 : head.r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= not_empty;
			if (not_empty) begin
				half_q <= !half_q && head.two;
			end
		end
	end

endmodule

@@ src/csv_field_splitter.sv @@
// CSV field splitter: one input transaction carries either a data byte or an end-of-input
// command, and the block can take one every clock cycle while in_stall is low. The front end
// classifies each byte and updates the parser state in the cycle it is accepted, producing
// zero, one or two result transactions; these wait in a four-entry queue and the back end
// sends them out one per cycle, while out_stall is low, from an output register; a result
// passes from the queue into the output register. Sustained throughput is one byte per
// cycle while each byte gives at most one result; a record end with fields gives two results,
// which the output register sends one after the other, and in_stall rises when the queue is
// full. The separator and quote character may be written only while the block is idle.
module csv_field_splitter #(
	parameter int unsigned MAX_FIELDS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [7:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input csvfs_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output csvfs_pkg::out_item_t out_item
);

	logic full;
	logic push;
	logic pop;
	logic not_empty;
	csvfs_pkg::entry_t push_entry;
	csvfs_pkg::entry_t head;

	assign in_stall = full;

	csvfs_front #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_item(in_item),
		.full(full),
		.push(push),
		.push_entry(push_entry)
	);

	csvfs_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.full(full),
		.not_empty(not_empty),
		.head(head)
	);

	csvfs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.not_empty(not_empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

endmodule

@@ src/csvfs_checker.sv @@
module csvfs_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input csvfs_pkg::out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("Stalled output transaction changed or was dropped.");

	a_eor_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == csvfs_pkg::KIND_EOR |-> out_item.last)
		else $error("End of record was not the last result of its input.");

	a_byte_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind != csvfs_pkg::KIND_EOR |-> out_item.field_count == 9'd0)
		else $error("Field count is nonzero outside an end of record.");

	a_empty_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == csvfs_pkg::KIND_EOR && out_item.field_count == 9'd0
		|-> out_item.field_index == 8'd0)
		else $error("Empty record carries a nonzero field index.");

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_item(out_item)
);

@@ tb/sv/csvfs_test_pkg.sv @@
package csvfs_test_pkg;
	import csvfs_pkg::*;

	localparam int unsigned FIELD_LIMIT = 256;
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END = 1'b1;

	class field_tracker;
		logic [7:0] separator;
		logic [7:0] quote_char;
		mode_t mode;
		bit cr_pending;
		bit line_has_bytes;
		bit line_has_text;
		bit line_cut;
		bit overflow;
		logic [8:0] field_no;
		out_item_t step_results[$];
		out_item_t awaited[$];
		int failures;

		function new();
			separator = SEPARATOR_RESET;
			quote_char = QUOTE_CHAR_RESET;
			cr_pending = 1'b0;
			failures = 0;
			start_line();
		endfunction

		function void set_register(logic idx, logic [7:0] value);
			if (idx == CFG_SEPARATOR) begin
				separator = value;
			end else begin
				quote_char = value;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void start_line();
			mode = MODE_START;
			line_has_bytes = 1'b0;
			line_has_text = 1'b0;
			line_cut = 1'b0;
			field_no = '0;
			overflow = 1'b0;
		endfunction

		function void add_result(logic [1:0] kind, logic [7:0] value, logic [7:0] index,
				logic [8:0] count);
			out_item_t r;
			r.kind = kind;
			r.out_byte = value;
			r.field_index = index;
			r.field_count = count;
			r.overflow = overflow;
			r.last = 1'b0;
			step_results.push_back(r);
		endfunction

		function void close_record();
			if (line_has_text) begin
				add_result(KIND_EOF, 8'd0, field_no[7:0], 9'd0);
				add_result(KIND_EOR, 8'd0, field_no[7:0], field_no + 9'd1);
			end else begin
				add_result(KIND_EOR, 8'd0, 8'd0, 9'd0);
			end
			start_line();
		endfunction

		function void take_plain(logic [7:0] b);
			if (b == separator) begin
				add_result(KIND_EOF, 8'd0, field_no[7:0], 9'd0);
				if (field_no < FIELD_LIMIT - 1) begin
					field_no++;
				end else begin
					overflow = 1'b1;
				end
				mode = MODE_START;
			end else begin
				add_result(KIND_BYTE, b, field_no[7:0], 9'd0);
				mode = MODE_PLAIN;
			end
		endfunction

		function void note_item(in_item_t it);
			logic [7:0] b;
			bit swallow;
			b = it.data_byte;
			step_results.delete();
			if (it.command == CMD_END) begin
				cr_pending = 1'b0;
				if (line_has_bytes) begin
					close_record();
				end else begin
					start_line();
				end
			end else begin
				swallow = cr_pending && b == CH_LF;
				cr_pending = 1'b0;
				if (swallow) begin
				end else if (b == CH_CR || b == CH_LF) begin
					close_record();
					cr_pending = (b == CH_CR);
				end else begin
					line_has_bytes = 1'b1;
					if (line_cut) begin
					end else if (b == CH_NUL) begin
						line_cut = 1'b1;
					end else begin
						line_has_text = 1'b1;
						case (mode)
							MODE_START: begin
								if (b == quote_char) begin
									mode = MODE_QUOTED;
								end else begin
									take_plain(b);
								end
							end
							MODE_QUOTED: begin
								if (b == quote_char) begin
									mode = MODE_QSEEN;
								end else begin
									add_result(KIND_BYTE, b, field_no[7:0], 9'd0);
								end
							end
							MODE_QSEEN: begin
								if (b == quote_char) begin
									add_result(KIND_BYTE, quote_char, field_no[7:0], 9'd0);
									mode = MODE_QUOTED;
								end else begin
									take_plain(b);
								end
							end
							default: begin
								take_plain(b);
							end
						endcase
					end
				end
			end
			if (step_results.size() != 0) begin
				step_results[step_results.size() - 1].last = 1'b1;
			end
			foreach (step_results[i]) begin
				awaited.push_back(step_results[i]);
			end
		endfunction

		function void check_field(string name, logic [8:0] want, logic [8:0] got);
			if (got !== want) begin
				failures++;
				$error("%s: expected %0d, actual %0d", name, want, got);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				failures++;
				$error("result transaction with none expected: kind %0d, out_byte %0d",
					got.kind, got.out_byte);
				return;
			end
			want = awaited.pop_front();
			check_field("kind", want.kind, got.kind);
			check_field("out_byte", want.out_byte, got.out_byte);
			check_field("field_index", want.field_index, got.field_index);
			check_field("field_count", want.field_count, got.field_count);
			check_field("overflow", want.overflow, got.overflow);
			check_field("last", want.last, got.last);
		endfunction
	endclass

endpackage

@@ tb/sv/csv_field_splitter_test.sv @@
module csv_field_splitter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import csvfs_pkg::*;
	import csvfs_test_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_PER_PHASE = 12;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [7:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	field_tracker tracker;
	int items_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_off_request = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;

	csv_field_splitter #(
		.MAX_FIELDS(FIELD_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tracker.note_item(in_item);
			end
			if (out_valid && !out_stall) begin
				tracker.check_result(out_item);
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic logic [7:0] text_byte();
		if ($urandom_range(9) < 7) begin
			return 8'h61 + 8'($urandom_range(25));
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] any_byte();
		int r;
		r = $urandom_range(99);
		if (r < 15) return tracker.separator;
		if (r < 27) return tracker.quote_char;
		if (r < 31) return CH_CR;
		if (r < 35) return CH_LF;
		if (r < 38) return CH_NUL;
		return text_byte();
	endfunction

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		in_item_t it;
		it.command = CMD_DATA;
		it.data_byte = b;
		send_item(it);
	endtask

	task automatic send_end(logic [7:0] junk);
		in_item_t it;
		it.command = CMD_END;
		it.data_byte = junk;
		send_item(it);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [7:0] sep, logic [7:0] quote);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SEPARATOR;
		cfg_data <= sep;
		@(posedge clk);
		cfg_index <= CFG_QUOTE_CHAR;
		cfg_data <= quote;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_register(CFG_SEPARATOR, sep);
		tracker.set_register(CFG_QUOTE_CHAR, quote);
		@(posedge clk);
	endtask

	task automatic send_directed();
		send_end(8'h00);
		send_byte(CH_LF);
		send_byte("a");
		send_byte(",");
		send_byte("\"");
		send_byte("b");
		send_byte(",");
		send_byte("\"");
		send_byte("\"");
		send_byte("c");
		send_byte("\"");
		send_byte("x");
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_NUL);
		send_byte("q");
		send_byte(CH_LF);
		send_byte("a");
		send_byte(CH_NUL);
		send_byte(",");
		send_byte(CH_LF);
		send_byte("\"");
		send_byte(8'hFF);
		send_end(8'hA5);
		send_byte(CH_CR);
		send_byte("k");
		send_end(8'h00);
	endtask

	task automatic send_record();
		int fields;
		int len;
		fields = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
		for (int f = 0; f < fields; f++) begin
			if (f > 0) send_byte(tracker.separator);
			len = $urandom_range(0, 4);
			if ($urandom_range(2) == 0) begin
				send_byte(tracker.quote_char);
				repeat (len) begin
					case ($urandom_range(5))
						0: begin
							send_byte(tracker.separator);
						end
						1: begin
							send_byte(tracker.quote_char);
							send_byte(tracker.quote_char);
						end
						default: begin
							send_byte(text_byte());
						end
					endcase
				end
				if ($urandom_range(6) != 0) begin
					send_byte(tracker.quote_char);
					if ($urandom_range(5) == 0) send_byte(text_byte());
				end
			end else begin
				repeat (len) begin
					send_byte(($urandom_range(7) == 0) ? tracker.quote_char : text_byte());
				end
			end
		end
		if ($urandom_range(15) == 0) begin
			send_byte(CH_NUL);
			send_byte(any_byte());
		end
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				send_byte(CH_LF);
			end
			4, 5: begin
				send_byte(CH_CR);
			end
			6, 7: begin
				send_byte(CH_CR);
				send_byte(CH_LF);
			end
			8: begin
				send_end(8'($urandom_range(255)));
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(19) == 0) begin
				send_end(8'($urandom_range(255)));
			end else begin
				send_byte(any_byte());
			end
		end
	endtask

	task automatic send_random(int count);
		int first;
		first = items_sent;
		while (items_sent - first < count) begin
			if ($urandom_range(4) == 0) begin
				send_noise();
			end else begin
				send_record();
			end
		end
	endtask

	task automatic send_long_record(int separators);
		for (int i = 0; i < separators; i++) begin
			if ($urandom_range(15) == 0) send_byte(text_byte());
			send_byte(tracker.separator);
		end
		send_byte("z");
		send_byte(CH_LF);
	endtask

	task automatic run_phase(logic [7:0] sep, logic [7:0] quote, int idle_level,
			int stall_level, bit with_hold);
		settle();
		configure(sep, quote);
		send_idle_pct = idle_level;
		stall_pct = stall_level;
		if (with_hold) begin
			hold_off_request = 1'b1;
			send_long_record(FIELD_LIMIT + 1);
		end
		send_random(RANDOM_PER_PHASE);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SEPARATOR;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure(SEPARATOR_RESET, QUOTE_CHAR_RESET);
		send_directed();
		send_random(RANDOM_PER_PHASE);
		run_phase(";", "'", 62, 0, 1'b0);
		run_phase(8'hFF, 8'h00, 0, 62, 1'b0);
		run_phase(8'h00, 8'hFF, 32, 32, 1'b0);
		run_phase("|", "|", 0, 0, 1'b0);
		run_phase(SEPARATOR_RESET, QUOTE_CHAR_RESET, 32, 32, 1'b1);
		run_phase(CH_LF, CH_CR, 0, 62, 1'b0);
		run_phase(SEPARATOR_RESET, QUOTE_CHAR_RESET, 62, 62, 1'b0);
		settle();
		if (tracker.failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/csvfs_pkg.sv
src/csvfs_front.sv
src/csvfs_fifo.sv
src/csvfs_back.sv
src/csv_field_splitter.sv
src/csvfs_checker.sv
tb/sv/csvfs_test_pkg.sv
tb/sv/csv_field_splitter_test.sv
